@@ design/sspm_pkg.sv @@
`timescale 1ns / 1ps

package sspm_pkg;

  localparam int SYM_W       = 8;
  localparam int POS_W       = 10;
  localparam int NUM_STACKS  = 27;
  localparam int STK_W       = 5;
  localparam int MAX_LEN_DEF = 1024;

  localparam logic [SYM_W-1:0] CH_OPEN    = 8'h3E;  // '>'
  localparam logic [SYM_W-1:0] CH_CLOSE   = 8'h3C;  // '<'
  localparam logic [SYM_W-1:0] CH_UPPER_A = 8'h41;  // 'A'
  localparam logic [SYM_W-1:0] CH_UPPER_Z = 8'h5A;  // 'Z'
  localparam logic [SYM_W-1:0] CH_LOWER_A = 8'h61;  // 'a'
  localparam logic [SYM_W-1:0] CH_LOWER_Z = 8'h7A;  // 'z'
  localparam logic [SYM_W-1:0] CH_ASCII_MAX = 8'd127;
  localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;
  localparam logic [SYM_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [SYM_W-1:0] CH_UNDER = 8'h5F;
  localparam logic [SYM_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [SYM_W-1:0] CH_TILDE = 8'h7E;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PUSH,
    OP_POP,
    OP_ERR
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [STK_W-1:0] stk;
  } decode_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             pair_found;
    logic [POS_W-1:0] partner_position;
    logic             symbol_error;
    logic             string_done;
    logic             string_ok;
  } out_item_t;

  function automatic decode_t decode_symbol(input logic [SYM_W-1:0] sym, input logic pk_en);
    decode_t          d;
    logic [SYM_W-1:0] idx;
    logic             gap;
    d   = '{op: OP_NONE, stk: '0};
    idx = '0;
    gap = (sym == CH_SPACE) || (sym == CH_DOT) || (sym == CH_UNDER) ||
          (sym == CH_DASH) || (sym == CH_TILDE);
    if (sym > CH_ASCII_MAX) begin
      d.op = OP_ERR;
    end else if (sym == CH_OPEN) begin
      d.op = OP_PUSH;
    end else if (sym == CH_CLOSE) begin
      d.op = OP_POP;
    end else if (pk_en && sym >= CH_UPPER_A && sym <= CH_UPPER_Z) begin
      idx   = sym - CH_UPPER_A + 8'd1;
      d.op  = OP_PUSH;
      d.stk = idx[STK_W-1:0];
    end else if (pk_en && sym >= CH_LOWER_A && sym <= CH_LOWER_Z) begin
      idx   = sym - CH_LOWER_A + 8'd1;
      d.op  = OP_POP;
      d.stk = idx[STK_W-1:0];
    end else if (pk_en && !gap) begin
      d.op = OP_ERR;
    end
    return d;
  endfunction

endpackage

@@ design/sspm_if.sv @@
`timescale 1ns / 1ps

interface sspm_in_if;
  logic                       valid;
  logic                       ready;
  logic [sspm_pkg::SYM_W-1:0] symbol;
  logic                       last_symbol;
  modport source (output valid, output symbol, output last_symbol, input ready);
  modport sink (input valid, input symbol, input last_symbol, output ready);
endinterface

interface sspm_out_if;
  logic                       valid;
  logic                       ready;
  logic [sspm_pkg::POS_W-1:0] position;
  logic                       pair_found;
  logic [sspm_pkg::POS_W-1:0] partner_position;
  logic                       symbol_error;
  logic                       string_done;
  logic                       string_ok;
  modport source (output valid, output position, output pair_found, output partner_position,
                  output symbol_error, output string_done, output string_ok, input ready);
  modport sink (input valid, input position, input pair_found, input partner_position,
                input symbol_error, input string_done, input string_ok, output ready);
endinterface

interface sspm_cfg_if;
  logic valid;
  logic ready;
  logic pseudoknots_enabled;
  modport source (output valid, output pseudoknots_enabled, input ready);
  modport sink (input valid, input pseudoknots_enabled, output ready);
endinterface

@@ design/sspm_ram.sv @@
`timescale 1ns / 1ps

module sspm_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/structure_string_pair_matcher_unit.sv @@
// Results are registered: each result enters the output register, or the skid register while the output is stalled.
// Throughput: one request per cycle while the skid register is empty; the link RAM's registered read is forwarded
// straight into the next request's stack lookup, so back-to-back pops on one stack do not stall.
// Reset (rst_n low, synchronous): all stacks empty, position, open count and error flag cleared,
// pseudoknots_enabled set to 1, output buffer emptied. The link RAM is not cleared.
`timescale 1ns / 1ps

module structure_string_pair_matcher_unit #(
  parameter int MAX_LEN = sspm_pkg::MAX_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sspm_in_if.sink     in_chan,
  sspm_out_if.source  out_chan,
  sspm_cfg_if.sink    cfg_chan
);

  localparam int PTR_W  = $clog2(MAX_LEN);
  localparam int HEAD_W = $clog2(MAX_LEN + 1);
  localparam int PW     = sspm_pkg::POS_W;
  localparam int NS     = sspm_pkg::NUM_STACKS;
  localparam int SW     = sspm_pkg::STK_W;
  localparam logic [HEAD_W-1:0] EMPTY = HEAD_W'(MAX_LEN);

  // Configuration register. Writes are always taken.
  logic pk_en_r;

  // Per-stack head pointers in flops; EMPTY marks an empty stack. Each pushed position
  // keeps the head below it in the link RAM.
  logic [HEAD_W-1:0] head_r   [NS];
  logic [HEAD_W-1:0] head_nxt [NS];

  logic [HEAD_W-1:0] pos_r, pos_nxt;
  logic [HEAD_W-1:0] cnt_r, cnt_nxt;
  logic              err_seen_r, err_seen_nxt;

  // Pending pop: the link RAM read issued last cycle returns the new head of this stack.
  logic          s1_v_r, s1_v_nxt;
  logic [SW-1:0] s1_stk_r, s1_stk_nxt;

  // Two-entry output buffer: the output register plus a skid register.
  sspm_pkg::out_item_t out_r, skid_r, res;
  logic                out_v_r, skid_v_r;

  logic                 acc, take, ovf, fwd, empty, do_push, do_pop, err;
  sspm_pkg::decode_t    dec;
  logic [HEAD_W-1:0]    head_eff;
  logic [HEAD_W-1:0]    ram_rdata;
  logic [HEAD_W-1:0]    shown;

  assign in_chan.ready  = !skid_v_r;
  assign cfg_chan.ready = 1'b1;
  assign acc  = in_chan.valid && in_chan.ready;
  assign take = out_v_r && out_chan.ready;

  // Decode and stack lookup. When the previous request popped the same stack, its new head
  // is still on the RAM read port and is taken from there.
  assign dec      = sspm_pkg::decode_symbol(in_chan.symbol, pk_en_r);
  assign ovf      = (pos_r >= EMPTY);
  assign fwd      = s1_v_r && (s1_stk_r == dec.stk);
  assign head_eff = fwd ? ram_rdata : head_r[dec.stk];
  assign empty    = (head_eff == EMPTY);

  assign do_push = acc && !ovf && (dec.op == sspm_pkg::OP_PUSH);
  assign do_pop  = acc && !ovf && (dec.op == sspm_pkg::OP_POP) && !empty;
  assign err     = ovf || (dec.op == sspm_pkg::OP_ERR) ||
                   ((dec.op == sspm_pkg::OP_POP) && empty);

  // A push links its position to the current head; a pop reads the link under the head.
  sspm_ram #(
    .WIDTH(HEAD_W),
    .DEPTH(MAX_LEN)
  ) u_link_ram (
    .clk  (clk),
    .we   (do_push),
    .waddr(pos_r[PTR_W-1:0]),
    .wdata(head_eff),
    .raddr(head_eff[PTR_W-1:0]),
    .rdata(ram_rdata)
  );

  // The end of a string clears everything, which also cancels its own pending pop.
  assign s1_v_nxt   = do_pop && !in_chan.last_symbol;
  assign s1_stk_nxt = dec.stk;

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      head_nxt[k] = head_r[k];
    end
    if (s1_v_r) begin
      head_nxt[s1_stk_r] = ram_rdata;
    end
    if (do_push) begin
      head_nxt[dec.stk] = pos_r;
    end
    if (acc && in_chan.last_symbol) begin
      for (int k = 0; k < NS; k++) begin
        head_nxt[k] = EMPTY;
      end
    end
  end

  always_comb begin
    cnt_nxt      = cnt_r;
    pos_nxt      = pos_r;
    err_seen_nxt = err_seen_r;
    if (acc) begin
      if (do_push) begin
        cnt_nxt = cnt_r + HEAD_W'(1);
      end else if (do_pop) begin
        cnt_nxt = cnt_r - HEAD_W'(1);
      end
      if (!ovf) begin
        pos_nxt = pos_r + HEAD_W'(1);
      end
      err_seen_nxt = err_seen_r || err;
    end
  end

  // Result of the request at the input. An overflowing request shows the last legal position.
  assign shown = ovf ? HEAD_W'(MAX_LEN - 1) : pos_r;

  always_comb begin
    res.position         = PW'(shown);
    res.pair_found       = do_pop;
    res.partner_position = do_pop ? PW'(head_eff) : '0;
    res.symbol_error     = err;
    res.string_done      = in_chan.last_symbol;
    res.string_ok        = in_chan.last_symbol && !err_seen_nxt && (cnt_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pk_en_r    <= 1'b1;
      pos_r      <= '0;
      cnt_r      <= '0;
      err_seen_r <= 1'b0;
      s1_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      skid_v_r   <= 1'b0;
      for (int k = 0; k < NS; k++) begin
        head_r[k] <= EMPTY;
      end
    end else begin
      if (cfg_chan.valid) begin
        pk_en_r <= cfg_chan.pseudoknots_enabled;
      end
      s1_v_r <= s1_v_nxt;
      for (int k = 0; k < NS; k++) begin
        head_r[k] <= head_nxt[k];
      end
      if (acc && in_chan.last_symbol) begin
        pos_r      <= '0;
        cnt_r      <= '0;
        err_seen_r <= 1'b0;
      end else begin
        pos_r      <= pos_nxt;
        cnt_r      <= cnt_nxt;
        err_seen_r <= err_seen_nxt;
      end
      // Output buffer: a new result goes to the output register when it is free or being
      // drained, otherwise to the skid register, which blocks further requests.
      if (acc) begin
        if (!out_v_r || take) begin
          out_v_r <= 1'b1;
        end else begin
          skid_v_r <= 1'b1;
        end
      end else if (take) begin
        if (skid_v_r) begin
          skid_v_r <= 1'b0;
        end else begin
          out_v_r <= 1'b0;
        end
      end
    end
  end

  // Pipeline and payload registers without reset.
  always_ff @(posedge clk) begin
    s1_stk_r <= s1_stk_nxt;
    if (acc) begin
      if (!out_v_r || take) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end else if (take && skid_v_r) begin
      out_r <= skid_r;
    end
  end

  assign out_chan.valid            = out_v_r;
  assign out_chan.position         = out_r.position;
  assign out_chan.pair_found       = out_r.pair_found;
  assign out_chan.partner_position = out_r.partner_position;
  assign out_chan.symbol_error     = out_r.symbol_error;
  assign out_chan.string_done      = out_r.string_done;
  assign out_chan.string_ok        = out_r.string_ok;

  // A pending head update always stems from a request accepted in the previous cycle.
  a_pending_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> $past(acc))
    else $error("pending pop without a preceding request");

  // Every open entry was pushed at an earlier position of the same string.
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= pos_r)
    else $error("open count exceeds position");

  // A successful pop never meets an empty count.
  a_pop_has_open: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |-> (cnt_r != '0))
    else $error("pop with no open entry");

  // The skid register is only used while the output register holds a result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register full with output register empty");

  // The end of a string leaves the string state cleared.
  a_string_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_chan.last_symbol) |=> (pos_r == '0 && cnt_r == '0 && !err_seen_r && !s1_v_r))
    else $error("string state not cleared after final request");

endmodule
